// ----- rtl/core/mmt_pkg.sv -----
// Shared types, constants and helper functions of the matrix product engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mmt_pkg;

  // Store geometry.
  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);

  // Field widths.
  localparam int DIM_W  = 5;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int STAT_W = 3;
  localparam int FORM_W = 2;
  localparam int MODE_W = 2;

  // Counter wide enough for a store index and for a dimension register.
  localparam int CNT_W = (IDX_W > DIM_W) ? IDX_W : DIM_W;

  // Exact sum of MAX_DIM products of two Q16.16 values.
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  // Command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_REQ  = 2'd2
  } mode_t;

  typedef enum logic [FORM_W-1:0] {
    FORM_AB  = 2'd0,
    FORM_ATB = 2'd1,
    FORM_ABT = 2'd2
  } form_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_INNER = 3'd1,
    ST_ROWS  = 3'd2,
    ST_COLS  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_A_ROWS   = 3'd0,
    REG_A_COLS   = 3'd1,
    REG_B_ROWS   = 3'd2,
    REG_B_COLS   = 3'd3,
    REG_RES_ROWS = 3'd4,
    REG_RES_COLS = 3'd5,
    REG_FORM     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  a_rows;
    logic [DIM_W-1:0]  a_cols;
    logic [DIM_W-1:0]  b_rows;
    logic [DIM_W-1:0]  b_cols;
    logic [DIM_W-1:0]  res_rows;
    logic [DIM_W-1:0]  res_cols;
    logic [FORM_W-1:0] form;
  } cfg_t;

  // One classified item: a store write or a checked product request.
  typedef struct packed {
    mode_t                   kind;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    status_t                 status;
    form_t                   form;
    logic [DIM_W-1:0]        inner;
  } cmd_t;

  // Store address of element (r, c), row major.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // Drop the sixteen fraction bits (rounding toward minus infinity) and
  // saturate to the Q16.16 range.
  function automatic logic signed [VAL_W-1:0] saturate(
      input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-VAL_W-FRAC_W:0] top;
    top = acc[ACC_W-1:VAL_W+FRAC_W-1];
    if (top == '0 || top == '1) begin
      return acc[VAL_W+FRAC_W-1:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mmt_if.sv -----
// Valid/ready channel interfaces of the matrix product engine: input items
// and result items. Depends on mmt_pkg.
`default_nettype none

interface mmt_in_if;
  import mmt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [POS_W-1:0]        row;
  logic [POS_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink (input valid, input mode, input row, input col, input value,
                output ready);
endinterface

interface mmt_out_if;
  import mmt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mmt_front.sv -----
// Front of the matrix product engine: takes input items, runs the dimension
// checks and turns kept items into queue commands. Depends on mmt_pkg, mmt_if.
`default_nettype none

module mmt_front (
  input  mmt_pkg::cfg_t cfg_i,
  mmt_in_if.sink        in_ch,
  input  logic          q_full_i,
  output logic          push_o,
  output mmt_pkg::cmd_t cmd_o
);
  import mmt_pkg::*;

  form_t            form;
  logic             mis_inner;
  logic             mis_rows;
  logic             mis_cols;
  logic             too_wide;
  logic             out_idx;
  logic             wr_ok;
  logic             keep;
  logic [DIM_W-1:0] inner;
  status_t          st;

  always_comb begin
    unique case (form_t'(cfg_i.form))
      FORM_ATB: form = FORM_ATB;
      FORM_ABT: form = FORM_ABT;
      default:  form = FORM_AB;
    endcase

    unique case (form)
      FORM_ATB: begin
        mis_inner = cfg_i.a_rows != cfg_i.b_rows;
        mis_rows  = cfg_i.a_cols != cfg_i.res_rows;
        mis_cols  = cfg_i.b_cols != cfg_i.res_cols;
        inner     = cfg_i.a_rows;
      end
      FORM_ABT: begin
        mis_inner = cfg_i.a_cols != cfg_i.b_cols;
        mis_rows  = cfg_i.a_rows != cfg_i.res_rows;
        mis_cols  = cfg_i.b_rows != cfg_i.res_cols;
        inner     = cfg_i.a_cols;
      end
      default: begin
        mis_inner = cfg_i.a_cols != cfg_i.b_rows;
        mis_rows  = cfg_i.a_rows != cfg_i.res_rows;
        mis_cols  = cfg_i.b_cols != cfg_i.res_cols;
        inner     = cfg_i.a_cols;
      end
    endcase

    too_wide = int'(cfg_i.a_rows) > MAX_DIM || int'(cfg_i.a_cols) > MAX_DIM ||
               int'(cfg_i.b_rows) > MAX_DIM || int'(cfg_i.b_cols) > MAX_DIM ||
               int'(cfg_i.res_rows) > MAX_DIM || int'(cfg_i.res_cols) > MAX_DIM;
    out_idx  = DIM_W'(in_ch.row) >= cfg_i.res_rows ||
               DIM_W'(in_ch.col) >= cfg_i.res_cols;

    priority if (mis_inner) begin
      st = ST_INNER;
    end else if (mis_rows) begin
      st = ST_ROWS;
    end else if (mis_cols) begin
      st = ST_COLS;
    end else if (too_wide || out_idx) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end

    wr_ok = int'(in_ch.row) < MAX_DIM && int'(in_ch.col) < MAX_DIM;

    unique case (mode_t'(in_ch.mode))
      MODE_WR_A: keep = wr_ok;
      MODE_WR_B: keep = wr_ok;
      MODE_REQ:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign cmd_o.kind   = mode_t'(in_ch.mode);
  assign cmd_o.row    = in_ch.row;
  assign cmd_o.col    = in_ch.col;
  assign cmd_o.value  = in_ch.value;
  assign cmd_o.status = st;
  assign cmd_o.form   = form;
  assign cmd_o.inner  = inner;

  // Unused modes and out-of-store writes are accepted and dropped here.
  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i && keep;

endmodule

`default_nettype wire

// ----- rtl/core/mmt_queue.sv -----
// Short command queue that decouples the front from the back of the matrix
// product engine. Depends on mmt_pkg.
`default_nettype none

module mmt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  mmt_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output mmt_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import mmt_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full_o  = count_r == QCNT_W'(QDEPTH);
  assign empty_o = count_r == '0;
  assign head_o  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/mmt_back.sv -----
// Back of the matrix product engine: owns the A and B stores, performs writes
// and runs the multiply-accumulate for requests. Depends on mmt_pkg, mmt_if.
`default_nettype none

module mmt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mmt_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  mmt_out_if.source     out_ch
);
  import mmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_RES   = 4'b1000
  } bstate_t;

  bstate_t                  state_r;
  bstate_t                  state_nxt;
  cmd_t                     cur_r;
  logic [CNT_W-1:0]         k_r;
  logic [CNT_W-1:0]         k_nxt;
  logic                     rd_v_r;
  logic                     prod_v_r;
  logic signed [VAL_W-1:0]  a_q_r;
  logic signed [VAL_W-1:0]  b_q_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic [STAT_W-1:0]        out_status_r;

  logic signed [VAL_W-1:0]  mem_a [MAX_DIM * MAX_DIM];
  logic signed [VAL_W-1:0]  mem_b [MAX_DIM * MAX_DIM];

  logic                     issue;
  logic                     last;
  logic                     start;
  logic                     load;
  logic                     we_a;
  logic                     we_b;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        raddr_a;
  logic [ADDR_W-1:0]        raddr_b;
  logic [CNT_W-1:0]         r_ext;
  logic [CNT_W-1:0]         c_ext;
  logic signed [VAL_W-1:0]  res_value;

  assign pop_o = (state_r == S_IDLE) && !empty_i;
  assign we_a  = pop_o && head_i.kind == MODE_WR_A;
  assign we_b  = pop_o && head_i.kind == MODE_WR_B;
  assign start = pop_o && head_i.kind == MODE_REQ;
  assign waddr = mem_addr(CNT_W'(head_i.row), CNT_W'(head_i.col));

  assign issue = state_r == S_RUN;
  assign last  = k_r == CNT_W'(cur_r.inner - DIM_W'(1));
  assign load  = (state_r == S_RES) && (!out_valid_r || out_ch.ready);
  assign r_ext = CNT_W'(cur_r.row);
  assign c_ext = CNT_W'(cur_r.col);

  assign res_value = (cur_r.status == ST_OK) ? saturate(acc_r) : '0;

  // Operand addresses for step k of the inner sum.
  always_comb begin
    unique case (cur_r.form)
      FORM_ATB: begin
        raddr_a = mem_addr(k_r, r_ext);
        raddr_b = mem_addr(k_r, c_ext);
      end
      FORM_ABT: begin
        raddr_a = mem_addr(r_ext, k_r);
        raddr_b = mem_addr(c_ext, k_r);
      end
      default: begin
        raddr_a = mem_addr(r_ext, k_r);
        raddr_b = mem_addr(k_r, c_ext);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (start) begin
          if (head_i.status == ST_OK && head_i.inner != '0) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_RES;
          end
        end
      end
      S_RUN: begin
        k_nxt = k_r + 1'b1;
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (start) begin
      cur_r <= head_i;
    end
    prod_r <= a_q_r * b_q_r;
    if (start) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (load) begin
      out_value_r  <= res_value;
      out_status_r <= cur_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= head_i.value;
    end
    if (issue) begin
      a_q_r <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= head_i.value;
    end
    if (issue) begin
      b_q_r <= mem_b[raddr_b];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    load && cur_r.status != ST_OK |-> res_value == '0)
    else $error("failed request would carry a non-zero value");

  a_pipe_follow: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> rd_v_r ##1 prod_v_r)
    else $error("operand pipeline lost a step");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RES |-> !rd_v_r && !prod_v_r)
    else $error("result taken before the sum was complete");

endmodule

`default_nettype wire

// ----- rtl/core/matrix_multiply_transpose_modes.sv -----
// Top level of the matrix product engine: configuration registers, front,
// command queue and back. Depends on mmt_pkg, mmt_if, mmt_front, mmt_queue, mmt_back.
//
//   Channel   Direction  Handshake              Carries
//   in_ch     sink       valid/ready            mode, row, col, value
//   out_ch    source     valid/ready            result_value, status
//   APB       slave      psel/penable, pready=1 seven registers at byte 4*i
//
// A store write is performed as it leaves the queue. A product request runs in
// the back one multiply-accumulate per cycle through the single read port of
// each store, then drains its operand and product registers; a request that
// fails its checks goes straight to its result. The front transfers items into
// a four-entry queue, so it keeps taking items while the back works or a result
// waits, until the queue is full. Reset (synchronous, rst_n low) empties the
// queue and the output register and sets every dimension to one and the form to
// A*B; the stores are not cleared and hold unknown data until written.
`default_nettype none

module matrix_multiply_transpose_modes (
  input  logic                          clk,
  input  logic                          rst_n,
  mmt_in_if.sink                        in_ch,
  mmt_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmt_pkg::PADDR_W-1:0]   paddr,
  input  logic [mmt_pkg::PDATA_W-1:0]   pwdata,
  output logic [mmt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mmt_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  cmd_t     push_cmd;
  cmd_t     head_cmd;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // The port never inserts wait states, so a write completes in its access
  // cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Only the low bits of the written data are kept; addresses past the last
  // register are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_A_ROWS:   cfg_nxt.a_rows   = pwdata[DIM_W-1:0];
        REG_A_COLS:   cfg_nxt.a_cols   = pwdata[DIM_W-1:0];
        REG_B_ROWS:   cfg_nxt.b_rows   = pwdata[DIM_W-1:0];
        REG_B_COLS:   cfg_nxt.b_cols   = pwdata[DIM_W-1:0];
        REG_RES_ROWS: cfg_nxt.res_rows = pwdata[DIM_W-1:0];
        REG_RES_COLS: cfg_nxt.res_cols = pwdata[DIM_W-1:0];
        REG_FORM:     cfg_nxt.form     = pwdata[FORM_W-1:0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A_ROWS:   prdata = PDATA_W'(cfg_r.a_rows);
      REG_A_COLS:   prdata = PDATA_W'(cfg_r.a_cols);
      REG_B_ROWS:   prdata = PDATA_W'(cfg_r.b_rows);
      REG_B_COLS:   prdata = PDATA_W'(cfg_r.b_cols);
      REG_RES_ROWS: prdata = PDATA_W'(cfg_r.res_rows);
      REG_RES_COLS: prdata = PDATA_W'(cfg_r.res_cols);
      REG_FORM:     prdata = PDATA_W'(cfg_r.form);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows   <= DIM_W'(1);
      cfg_r.a_cols   <= DIM_W'(1);
      cfg_r.b_rows   <= DIM_W'(1);
      cfg_r.b_cols   <= DIM_W'(1);
      cfg_r.res_rows <= DIM_W'(1);
      cfg_r.res_cols <= DIM_W'(1);
      cfg_r.form     <= FORM_AB;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front checks each request against the registers at the moment of transfer;
  // the user must change the registers only while idle; the block does not check.
  mmt_front u_front (
    .cfg_i    (cfg_r),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Writes travel through the queue too, so a request always sees every
  // write that was transferred before it.
  mmt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mmt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_i  (head_cmd),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- dv/matrix_multiply_transpose_modes_tb.sv -----
// Self-checking testbench of the matrix product engine: store writes, product
// requests under every form and the dimension checks, with random idling.
// Depends on mmt_pkg, mmt_if and the top level matrix_multiply_transpose_modes.

module matrix_multiply_transpose_modes_tb;
  import mmt_pkg::*;

  // Codes that the package does not name: the spare input mode and the spare
  // product form, which the block treats as A*B.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [FORM_W-1:0] FORM_SPARE  = 2'd3;

  localparam int ITEM_TARGET   = 450;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  // Wide enough for the exact sum of sixteen Q32.32 products.
  localparam int ACC_BITS = 80;
  localparam logic signed [ACC_BITS-1:0] Q_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [ACC_BITS-1:0] Q_MIN = -80'sh8000_0000;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
  } product_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mmt_in_if  in_bus ();
  mmt_out_if out_bus ();

  matrix_multiply_transpose_modes i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the configuration registers and of both stores. The
  // configuration copy is updated when an APB write completes; the store
  // copies are updated when a write item is transferred into the block.
  cfg_t                    shadow_cfg;
  logic signed [VAL_W-1:0] a_mirror [MAX_DIM*MAX_DIM];
  logic signed [VAL_W-1:0] b_mirror [MAX_DIM*MAX_DIM];

  // Store entries already written by queued items. The stores hold unknown
  // data after reset, so a request that would read an entry not yet written
  // is preceded by a write of that entry.
  bit a_written [MAX_DIM*MAX_DIM];
  bit b_written [MAX_DIM*MAX_DIM];

  item_t    item_backlog [$];
  product_t awaited_products [$];
  item_t    next_item;
  product_t want;

  int  queued_items = 0;
  int  items_in = 0;
  int  requests_in = 0;
  int  results_out = 0;
  int  ok_results = 0;
  int  faults = 0;
  int  settings_applied = 0;
  int  idle_cycles = 0;
  int  send_gap;
  int  sink_stall;
  bit  calm;

  function automatic int store_slot(input int r, input int c);
    return r * MAX_DIM + c;
  endfunction

  // The spare form code behaves as A*B.
  function automatic form_t active_form();
    return (shadow_cfg.form == FORM_SPARE) ? FORM_AB : form_t'(shadow_cfg.form);
  endfunction

  // Dimension checks of a request, in the order in which the block applies
  // them: inner size, result rows, result columns, then range.
  function automatic status_t classify_request(input logic [POS_W-1:0] r,
                                               input logic [POS_W-1:0] c,
                                               output int inner);
    status_t st;
    st = ST_OK;
    case (active_form())
      FORM_ATB: begin
        if (shadow_cfg.a_rows != shadow_cfg.b_rows) st = ST_INNER;
        else if (shadow_cfg.a_cols != shadow_cfg.res_rows) st = ST_ROWS;
        else if (shadow_cfg.b_cols != shadow_cfg.res_cols) st = ST_COLS;
        inner = shadow_cfg.a_rows;
      end
      FORM_ABT: begin
        if (shadow_cfg.a_cols != shadow_cfg.b_cols) st = ST_INNER;
        else if (shadow_cfg.a_rows != shadow_cfg.res_rows) st = ST_ROWS;
        else if (shadow_cfg.b_rows != shadow_cfg.res_cols) st = ST_COLS;
        inner = shadow_cfg.a_cols;
      end
      default: begin
        if (shadow_cfg.a_cols != shadow_cfg.b_rows) st = ST_INNER;
        else if (shadow_cfg.a_rows != shadow_cfg.res_rows) st = ST_ROWS;
        else if (shadow_cfg.b_cols != shadow_cfg.res_cols) st = ST_COLS;
        inner = shadow_cfg.a_cols;
      end
    endcase
    if (st == ST_OK && (shadow_cfg.a_rows > MAX_DIM || shadow_cfg.a_cols > MAX_DIM ||
                        shadow_cfg.b_rows > MAX_DIM || shadow_cfg.b_cols > MAX_DIM ||
                        shadow_cfg.res_rows > MAX_DIM || shadow_cfg.res_cols > MAX_DIM ||
                        r >= shadow_cfg.res_rows || c >= shadow_cfg.res_cols)) begin
      st = ST_RANGE;
    end
    return st;
  endfunction

  // Store entries multiplied together in term k of element (r, c).
  function automatic void term_slots(input int r, input int c, input int k,
                                     output int a_slot, output int b_slot);
    case (active_form())
      FORM_ATB: begin
        a_slot = store_slot(k, r);
        b_slot = store_slot(k, c);
      end
      FORM_ABT: begin
        a_slot = store_slot(r, k);
        b_slot = store_slot(c, k);
      end
      default: begin
        a_slot = store_slot(r, k);
        b_slot = store_slot(k, c);
      end
    endcase
  endfunction

  // One element of the configured product: exact sum, arithmetic shift by the
  // fraction width (rounding toward minus infinity), then saturation.
  function automatic product_t compute_product_element(input logic [POS_W-1:0] r,
                                                       input logic [POS_W-1:0] c);
    product_t                   res;
    int                         inner;
    int                         a_slot;
    int                         b_slot;
    logic signed [ACC_BITS-1:0] acc;
    logic signed [ACC_BITS-1:0] scaled;
    res.status = classify_request(r, c, inner);
    res.value  = '0;
    if (res.status == ST_OK) begin
      acc = '0;
      for (int k = 0; k < inner; k++) begin
        term_slots(r, c, k, a_slot, b_slot);
        acc += longint'(a_mirror[a_slot]) * longint'(b_mirror[b_slot]);
      end
      scaled = acc >>> FRAC_W;
      if (scaled > Q_MAX) res.value = {1'b0, {(VAL_W-1){1'b1}}};
      else if (scaled < Q_MIN) res.value = {1'b1, {(VAL_W-1){1'b0}}};
      else res.value = scaled[VAL_W-1:0];
    end
    return res;
  endfunction

  // Applies one transferred input item to our copy of the block.
  function automatic void absorb_item(input logic [MODE_W-1:0] mode,
                                      input logic [POS_W-1:0] row,
                                      input logic [POS_W-1:0] col,
                                      input logic signed [VAL_W-1:0] value);
    items_in++;
    case (mode)
      MODE_WR_A: a_mirror[store_slot(row, col)] = value;
      MODE_WR_B: b_mirror[store_slot(row, col)] = value;
      MODE_REQ: begin
        requests_in++;
        awaited_products.push_back(compute_product_element(row, col));
      end
      default: ; // the spare mode is dropped by the block
    endcase
  endfunction

  // Element values: edge values, full-range noise and small numbers between minus eight and eight.
  function automatic logic signed [VAL_W-1:0] rand_q16();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 6))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0001_0000;
        4: return 32'hFFFF_0000;
        5: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (pick < 4) return $urandom;
    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
  endfunction

  // Idle length between transfers: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Matrix sizes: mostly small, now and then up to the full store.
  function automatic int pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return MAX_DIM;
    if (roll < 4) return $urandom_range(5, MAX_DIM - 1);
    return $urandom_range(1, 4);
  endfunction

  // An index inside a declared dimension, or anywhere when it has none or exceeds the store.
  function automatic int pick_pos(input int limit);
    if (limit == 0 || limit > MAX_DIM) return $urandom_range(0, MAX_DIM - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  task automatic queue_item(input logic [MODE_W-1:0] mode, input int row, input int col,
                            input logic signed [VAL_W-1:0] value);
    item_t it;
    it.mode  = mode;
    it.row   = POS_W'(row);
    it.col   = POS_W'(col);
    it.value = value;
    if (mode == MODE_WR_A) a_written[store_slot(row, col)] = 1'b1;
    if (mode == MODE_WR_B) b_written[store_slot(row, col)] = 1'b1;
    if (mode != MODE_UNUSED) queued_items++;
    item_backlog.push_back(it);
  endtask

  // Queues a request, first writing any entry that it would read and that has
  // never been written.
  task automatic queue_request(input int row, input int col);
    int inner;
    int a_slot;
    int b_slot;
    if (classify_request(POS_W'(row), POS_W'(col), inner) == ST_OK) begin
      for (int k = 0; k < inner; k++) begin
        term_slots(row, col, k, a_slot, b_slot);
        if (!a_written[a_slot]) begin
          queue_item(MODE_WR_A, a_slot / MAX_DIM, a_slot % MAX_DIM, rand_q16());
        end
        if (!b_written[b_slot]) begin
          queue_item(MODE_WR_B, b_slot / MAX_DIM, b_slot % MAX_DIM, rand_q16());
        end
      end
    end
    queue_item(MODE_REQ, row, col, $urandom);
  endtask

  // Waits until every queued item has been transferred and every expected
  // result has arrived, then lets the block finish any trailing writes. The
  // condition is sampled at the falling edge, once the driver and the monitor
  // have settled.
  task automatic settle();
    while (!(item_backlog.size() == 0 && !in_bus.valid && awaited_products.size() == 0)) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle. Bits above the register
  // width carry noise, which the block must discard.
  task automatic apb_write(input reg_idx_t idx, input int unsigned val);
    logic [PDATA_W-1:0] keep;
    keep = (idx == REG_FORM) ? 32'h3 : 32'h1F;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= ($urandom & ~keep) | (val & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_A_ROWS:   shadow_cfg.a_rows   = DIM_W'(val);
      REG_A_COLS:   shadow_cfg.a_cols   = DIM_W'(val);
      REG_B_ROWS:   shadow_cfg.b_rows   = DIM_W'(val);
      REG_B_COLS:   shadow_cfg.b_cols   = DIM_W'(val);
      REG_RES_ROWS: shadow_cfg.res_rows = DIM_W'(val);
      REG_RES_COLS: shadow_cfg.res_cols = DIM_W'(val);
      default:      shadow_cfg.form     = FORM_W'(val);
    endcase
  endtask

  // Registers are only ever changed with the block idle.
  task automatic apply_setting(input int ar, input int ac, input int br, input int bc,
                               input int rr, input int rc, input int form);
    settle();
    apb_write(REG_A_ROWS, ar);
    apb_write(REG_A_COLS, ac);
    apb_write(REG_B_ROWS, br);
    apb_write(REG_B_COLS, bc);
    apb_write(REG_RES_ROWS, rr);
    apb_write(REG_RES_COLS, rc);
    apb_write(REG_FORM, form);
    settings_applied++;
  endtask

  // One random phase. A shaped phase declares consistent dimensions for its
  // form so that most requests are computed; otherwise each register drifts
  // away from a common size at random and the checks mostly reject.
  task automatic run_phase(input bit shaped);
    int m;
    int n;
    int p;
    int f;
    int base;
    int count;
    int unsigned roll;
    f = $urandom_range(0, 3);
    if (shaped) begin
      m = pick_size();
      n = pick_size();
      p = ($urandom_range(0, 24) == 0) ? 0 : pick_size();
      case (f)
        FORM_ATB: apply_setting(p, m, p, n, m, n, f);
        FORM_ABT: apply_setting(m, p, n, p, m, n, f);
        default:  apply_setting(m, p, p, n, m, n, f);
      endcase
    end else begin
      base = pick_size();
      apply_setting(($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31),
                    ($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31),
                    ($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31),
                    ($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31),
                    ($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31),
                    ($urandom_range(0, 3) != 0) ? base : $urandom_range(0, 31), f);
    end
    count = $urandom_range(6, 24);
    repeat (count) begin
      roll = $urandom_range(0, 19);
      if (roll < 11) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_request($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
        end else begin
          queue_request(pick_pos(shadow_cfg.res_rows), pick_pos(shadow_cfg.res_cols));
        end
      end else if (roll < 18) begin
        queue_item(($urandom_range(0, 1) != 0) ? MODE_WR_B : MODE_WR_A,
                   $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                   rand_q16());
      end else begin
        queue_item(MODE_UNUSED, $urandom_range(0, MAX_DIM - 1),
                   $urandom_range(0, MAX_DIM - 1), $urandom);
      end
    end
  endtask

  // Driver. An item is transferred at an edge where valid and ready are both
  // high; the item is handed to the predictor there, and the next one (or a
  // gap) is set up in the same step, with valid assigned only once.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_item(in_bus.mode, in_bus.row, in_bus.col, in_bus.value);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          in_bus.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (item_backlog.size() > 0) begin
          next_item = item_backlog.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.mode  <= next_item.mode;
          in_bus.row   <= next_item.row;
          in_bus.col   <= next_item.col;
          in_bus.value <= next_item.value;
          send_gap     <= pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result transfer is matched against the oldest expected
  // product element; ready is withdrawn now and then for a random stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_stall    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_out++;
        if (awaited_products.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("unexpected result: value %h status %0d",
                     out_bus.result_value, out_bus.status);
          end
        end else begin
          want = awaited_products.pop_front();
          if (want.status == ST_OK) ok_results++;
          if (out_bus.result_value !== want.value || out_bus.status !== want.status) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("result %0d: expected value %h status %0d, got value %h status %0d",
                       results_out, want.value, want.status,
                       out_bus.result_value, out_bus.status);
            end
          end
        end
      end
      if (sink_stall > 0) begin
        out_bus.ready <= 1'b0;
        sink_stall    <= sink_stall - 1;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_stall <= pick_gap();
      end
    end
  end

  // Watchdog: a long stretch with no transfer on any port means the block
  // has hung. The longest quiet stretch of a correct run is a settling pause
  // plus a few queued requests behind a long stall, far below the limit.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles < STALL_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_products.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = '0;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.value  = '0;
    out_bus.ready = 1'b0;
    calm          = 1'b0;
    shadow_cfg.a_rows   = 5'd1;
    shadow_cfg.a_cols   = 5'd1;
    shadow_cfg.b_rows   = 5'd1;
    shadow_cfg.b_cols   = 5'd1;
    shadow_cfg.res_rows = 5'd1;
    shadow_cfg.res_cols = 5'd1;
    shadow_cfg.form     = FORM_AB;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Two-by-two matrices built from edge values. The four elements cover
    // saturation at both ends and an exact negative result.
    apply_setting(2, 2, 2, 2, 2, 2, FORM_AB);
    queue_item(MODE_WR_A, 0, 0, 32'h7FFF_FFFF);
    queue_item(MODE_WR_A, 0, 1, 32'h7FFF_FFFF);
    queue_item(MODE_WR_A, 1, 0, 32'h8000_0000);
    queue_item(MODE_WR_A, 1, 1, 32'h0001_0000);
    queue_item(MODE_WR_B, 0, 0, 32'h7FFF_FFFF);
    queue_item(MODE_WR_B, 0, 1, 32'hFFFF_FFFF);
    queue_item(MODE_WR_B, 1, 0, 32'h0000_0001);
    queue_item(MODE_WR_B, 1, 1, 32'hFFFF_0000);
    queue_request(0, 0);
    queue_request(0, 1);
    queue_request(1, 0);
    queue_request(1, 1);
    queue_request(2, 1);
    queue_request(0, 15);
    queue_item(MODE_UNUSED, 15, 15, 32'hFFFF_FFFF);

    // The same data under each transposed form and the spare form code.
    apply_setting(2, 2, 2, 2, 2, 2, FORM_ATB);
    queue_request(1, 1);
    apply_setting(2, 2, 2, 2, 2, 2, FORM_ABT);
    queue_request(1, 0);
    apply_setting(2, 2, 2, 2, 2, 2, FORM_SPARE);
    queue_request(0, 1);

    // Each mismatch check on its own: inner size, result rows, result columns.
    apply_setting(2, 3, 2, 2, 2, 2, FORM_AB);
    queue_request(0, 0);
    apply_setting(2, 2, 2, 2, 3, 2, FORM_AB);
    queue_request(0, 0);
    apply_setting(2, 2, 2, 2, 2, 3, FORM_AB);
    queue_request(0, 0);

    // An empty inner dimension sums to zero; an empty result dimension puts
    // every request out of range, as do registers wider than the stores.
    apply_setting(2, 0, 0, 2, 2, 2, FORM_AB);
    queue_request(1, 1);
    apply_setting(0, 2, 2, 2, 0, 2, FORM_AB);
    queue_request(0, 0);
    apply_setting(31, 31, 31, 31, 31, 31, FORM_ABT);
    queue_request(15, 15);

    // Random phases, three in four of them with consistent dimensions.
    while (queued_items < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      run_phase($urandom_range(0, 3) != 0);
    end
    settle();

    $display("%0d input transfers including %0d product requests, under %0d register settings",
             items_in, requests_in, settings_applied);
    $display("%0d result transfers: %0d computed, %0d rejected by the dimension checks",
             results_out, ok_results, results_out - ok_results);
    if (awaited_products.size() != 0) begin
      $display("%0d product results never arrived", awaited_products.size());
      faults += awaited_products.size();
    end
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
